// ===== rtl/hta_pkg.sv =====
// Shared types, constants and helper functions for the handle table allocator.
// Used by the controller, the datapath and the top level.
package hta_pkg;

  localparam int SLOTS          = 64;
  localparam int HANDLE_BASE    = 256;
  localparam int RESERVED_SLOTS = 3;
  localparam int CONSOLE_SLOTS  = 3;

  localparam int IDX_W    = $clog2(SLOTS);
  localparam int HANDLE_W = 16;
  localparam int TYPE_W   = 4;
  localparam int DESC_W   = 16;
  localparam int ACC_W    = 32;
  localparam int TAG_W    = 32;

  localparam logic [TYPE_W-1:0] CONSOLE_TYPE = 4'd2;
  localparam logic [ACC_W-1:0]  ACCESS_READ  = 32'h8000_0000;
  localparam logic [ACC_W-1:0]  ACCESS_WRITE = 32'h4000_0000;
  localparam logic [DESC_W-1:0] DESC_NONE    = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_CREATE     = 2'd0,
    KIND_CREATE_TAG = 2'd1,
    KIND_LOOKUP     = 2'd2,
    KIND_CLOSE      = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_lookup;
  } cmd_t;

  typedef struct packed {
    logic need_read;
    logic res_busy;
  } status_t;

  typedef struct packed {
    logic [TYPE_W-1:0] obj_type;
    logic [DESC_W-1:0] descriptor;
    logic [TAG_W-1:0]  tag;
  } main_word_t;

  localparam int MAIN_W = $bits(main_word_t);

  function automatic main_word_t reset_main(input logic [IDX_W-1:0] idx);
    main_word_t w;
    w = '0;
    if (idx < IDX_W'(CONSOLE_SLOTS)) begin
      w.obj_type   = CONSOLE_TYPE;
      w.descriptor = DESC_W'(idx);
    end
    return w;
  endfunction

  function automatic logic [ACC_W-1:0] reset_access(input logic [IDX_W-1:0] idx);
    logic [ACC_W-1:0] a;
    a = '0;
    if (idx == '0) begin
      a = ACCESS_READ;
    end else if (idx < IDX_W'(CONSOLE_SLOTS)) begin
      a = ACCESS_WRITE;
    end
    return a;
  endfunction

endpackage

// ===== rtl/hta_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module hta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/hta_ctrl.sv =====
// Controller state machine: request handshake and slot memory read sequencing.
// Depends on hta_pkg.
module hta_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic              res_ready,
  input  hta_pkg::status_t  status,
  output hta_pkg::cmd_t     cmd
);
  import hta_pkg::*;

  state_t state;
  state_t state_next;
  logic   res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    res_free        = !status.res_busy || res_ready;
    state_next      = state;
    req_ready       = 1'b0;
    cmd.accept      = 1'b0;
    cmd.load_lookup = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready  = res_free;
        cmd.accept = req_valid && res_free;
        if (cmd.accept && status.need_read) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (res_free) begin
          cmd.load_lookup = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/hta_dp.sv =====
// Datapath: slot memories, occupancy and written bits, free slot search, result register.
// Depends on hta_pkg and hta_ram.
module hta_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  hta_pkg::cmd_t                        cmd,
  output hta_pkg::status_t                     status,
  input  logic [1:0]                           kind,
  input  logic [hta_pkg::HANDLE_W-1:0]         handle_in,
  input  logic [hta_pkg::TYPE_W-1:0]           obj_type,
  input  logic signed [hta_pkg::DESC_W-1:0]    descriptor_in,
  input  logic [hta_pkg::ACC_W-1:0]            access_in,
  input  logic [hta_pkg::TAG_W-1:0]            tag_in,
  input  logic                                 res_ready,
  output logic                                 res_valid,
  output logic                                 ok,
  output logic [hta_pkg::HANDLE_W-1:0]         handle_out,
  output logic [hta_pkg::TYPE_W-1:0]           type_out,
  output logic signed [hta_pkg::DESC_W-1:0]    descriptor_out,
  output logic [hta_pkg::ACC_W-1:0]            access_out,
  output logic [hta_pkg::TAG_W-1:0]            tag_out
);
  import hta_pkg::*;

  logic [SLOTS-1:0]    used;
  logic [SLOTS-1:0]    main_written;
  logic [SLOTS-1:0]    acc_written;
  logic [SLOTS-1:0]    free_vec;
  logic [SLOTS-1:0]    lowest;
  logic [IDX_W-1:0]    alloc_idx;
  logic                full;
  logic [HANDLE_W:0]   hoff;
  logic                in_range;
  logic [IDX_W-1:0]    hidx;
  logic                is_create;
  logic                create_ok;
  logic                close_ok;
  logic                main_we;
  logic                acc_we;
  logic [IDX_W-1:0]    waddr;
  main_word_t          main_wdata;
  logic [ACC_W-1:0]    acc_wdata;
  main_word_t          main_rdata;
  logic [ACC_W-1:0]    acc_rdata;
  logic [IDX_W-1:0]    rd_idx;
  logic [HANDLE_W-1:0] rd_handle;
  logic                rd_main_ok;
  logic                rd_acc_ok;
  main_word_t          lk_main;
  logic [ACC_W-1:0]    lk_acc;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free_vec[i] = !used[i] && (i >= RESERVED_SLOTS);
    end
    lowest    = free_vec & (~free_vec + SLOTS'(1));
    full      = (free_vec == '0);
    alloc_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (lowest[i]) begin
        alloc_idx = alloc_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    hoff     = {1'b0, handle_in} - (HANDLE_W + 1)'(HANDLE_BASE);
    in_range = !hoff[HANDLE_W] && (hoff < (HANDLE_W + 1)'(SLOTS));
    hidx     = hoff[IDX_W-1:0];
  end

  always_comb begin
    is_create        = (kind == KIND_CREATE) || (kind == KIND_CREATE_TAG);
    create_ok        = is_create && !full;
    close_ok         = (kind == KIND_CLOSE) && in_range;
    status.need_read = (kind == KIND_LOOKUP) && in_range && used[hidx];
    status.res_busy  = res_valid;
    main_we          = cmd.accept && (create_ok || close_ok);
    acc_we           = cmd.accept && create_ok;
    waddr            = create_ok ? alloc_idx : hidx;
    main_wdata       = '0;
    acc_wdata        = '0;
    case (kind)
      KIND_CREATE: begin
        main_wdata.obj_type   = obj_type;
        main_wdata.descriptor = descriptor_in;
        acc_wdata             = access_in;
      end
      KIND_CREATE_TAG: begin
        main_wdata.obj_type   = obj_type;
        main_wdata.descriptor = DESC_NONE;
        main_wdata.tag        = tag_in;
      end
      default: begin
        main_wdata.descriptor = DESC_NONE;
      end
    endcase
  end

  hta_ram #(.WIDTH(MAIN_W), .DEPTH(SLOTS)) u_main_ram (
    .clk   (clk),
    .we    (main_we),
    .waddr (waddr),
    .wdata (main_wdata),
    .re    (cmd.accept && status.need_read),
    .raddr (hidx),
    .rdata (main_rdata)
  );

  hta_ram #(.WIDTH(ACC_W), .DEPTH(SLOTS)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (waddr),
    .wdata (acc_wdata),
    .re    (cmd.accept && status.need_read),
    .raddr (hidx),
    .rdata (acc_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      used         <= SLOTS'((1 << CONSOLE_SLOTS) - 1);
      main_written <= '0;
      acc_written  <= '0;
    end else begin
      if (main_we) begin
        used[waddr]         <= create_ok && (obj_type != '0);
        main_written[waddr] <= 1'b1;
      end
      if (acc_we) begin
        acc_written[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && status.need_read) begin
      rd_idx     <= hidx;
      rd_handle  <= handle_in;
      rd_main_ok <= main_written[hidx];
      rd_acc_ok  <= acc_written[hidx];
    end
  end

  always_comb begin
    lk_main = rd_main_ok ? main_rdata : reset_main(rd_idx);
    lk_acc  = rd_acc_ok ? acc_rdata : reset_access(rd_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((cmd.accept && !status.need_read) || cmd.load_lookup) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_lookup) begin
      ok             <= 1'b1;
      handle_out     <= rd_handle;
      type_out       <= lk_main.obj_type;
      descriptor_out <= lk_main.descriptor;
      access_out     <= lk_acc;
      tag_out        <= lk_main.tag;
    end else if (cmd.accept && !status.need_read) begin
      ok             <= create_ok || close_ok;
      handle_out     <= create_ok ? HANDLE_W'(alloc_idx) + HANDLE_W'(HANDLE_BASE) :
                        close_ok  ? handle_in : '0;
      type_out       <= '0;
      descriptor_out <= '0;
      access_out     <= '0;
      tag_out        <= '0;
    end
  end

endmodule

// ===== rtl/handle_table_allocator.sv =====
// Handle table allocator top level: controller plus datapath.
// Depends on hta_pkg, hta_ctrl, hta_dp and hta_ram.
//
// A table of SLOTS object slots handed out as handles (slot index plus
// HANDLE_BASE). Create, create-with-tag and close answer in the cycle after
// the request is taken; a lookup of an occupied slot reads the slot memories
// into their registered read data, then loads the result register once free.
// A new request is taken in the idle state once the result register is empty
// or being emptied: one request per cycle for create and close while results
// are taken, none while a lookup waits. Slots 0 to 2 come out of reset as
// consoles and need no clearing pass; the table is usable once reset ends.
module handle_table_allocator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  logic [1:0]                           kind,
  input  logic [hta_pkg::HANDLE_W-1:0]         handle_in,
  input  logic [hta_pkg::TYPE_W-1:0]           obj_type,
  input  logic signed [hta_pkg::DESC_W-1:0]    descriptor_in,
  input  logic [hta_pkg::ACC_W-1:0]            access_in,
  input  logic [hta_pkg::TAG_W-1:0]            tag_in,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic                                 ok,
  output logic [hta_pkg::HANDLE_W-1:0]         handle_out,
  output logic [hta_pkg::TYPE_W-1:0]           type_out,
  output logic signed [hta_pkg::DESC_W-1:0]    descriptor_out,
  output logic [hta_pkg::ACC_W-1:0]            access_out,
  output logic [hta_pkg::TAG_W-1:0]            tag_out
);
  import hta_pkg::*;

  cmd_t    cmd;
  status_t status;

  hta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .res_ready (res_ready),
    .status    (status),
    .cmd       (cmd)
  );

  hta_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .kind           (kind),
    .handle_in      (handle_in),
    .obj_type       (obj_type),
    .descriptor_in  (descriptor_in),
    .access_in      (access_in),
    .tag_in         (tag_in),
    .res_ready      (res_ready),
    .res_valid      (res_valid),
    .ok             (ok),
    .handle_out     (handle_out),
    .type_out       (type_out),
    .descriptor_out (descriptor_out),
    .access_out     (access_out),
    .tag_out        (tag_out)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd.load_lookup |-> !cmd.accept)
    else $error("lookup load overlaps a new request");

  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && !status.need_read) |=> res_valid)
    else $error("missing result after create or close");

  a_handle_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && ok) |-> (handle_out >= HANDLE_W'(HANDLE_BASE)) &&
      ({1'b0, handle_out} < (HANDLE_W + 1)'(HANDLE_BASE + SLOTS)))
    else $error("successful result with handle out of table range");

endmodule
